FILE: rtl/mtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared widths, codes and types for the memory type resolver.
// ----------------------------------------------------------------------------
package mtr_pkg;

	localparam int NUM_RANGES_DEF = 8;
	localparam int MAX_PAGES_DEF  = 512;

	localparam int PFN_W   = 40;
	localparam int TYPE_W  = 8;
	localparam int ADDR_W  = 52;
	localparam int SIZE_W  = 22;
	localparam int SLOT_W  = 3;

	localparam int PAGE_BYTES  = 'h1000;
	localparam int PAGE_OFFSET = 'hFFF;
	localparam int FIXED_LIMIT = 'h100;
	localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
	localparam int FIXED_SHIFT = $clog2(FIXED_LIMIT);
	localparam int PCNT_W      = SIZE_W + 1 - PAGE_SHIFT;

	localparam int S_DATA_W = 168;
	localparam int M_DATA_W = 8;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_TYPING_EN       = 2'd0,
		REG_FIXED_SUPPORTED = 2'd1,
		REG_FIXED_ENABLE    = 2'd2,
		REG_DEFAULT_TYPE    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              typing_en;
		logic              fixed_supported;
		logic              fixed_enable;
		logic [TYPE_W-1:0] default_type;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [PFN_W-1:0]  base;
		logic [PFN_W-1:0]  mask;
		logic [TYPE_W-1:0] kind;
		logic              valid;
	} tbl_wr_t;

endpackage

FILE: rtl/mtr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtr_cfg
// Register file behind the configuration port.
// ----------------------------------------------------------------------------
module mtr_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mtr_pkg::APB_AW-1:0] paddr,
	input  logic [mtr_pkg::APB_DW-1:0] pwdata,
	output logic [mtr_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output mtr_pkg::cfg_t              cfg
);
	import mtr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_TYPING_EN:       cfg_q.typing_en       <= pwdata[0];
				REG_FIXED_SUPPORTED: cfg_q.fixed_supported <= pwdata[0];
				REG_FIXED_ENABLE:    cfg_q.fixed_enable    <= pwdata[0];
				REG_DEFAULT_TYPE:    cfg_q.default_type    <= pwdata[TYPE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TYPING_EN:       prdata = APB_DW'(cfg_q.typing_en);
			REG_FIXED_SUPPORTED: prdata = APB_DW'(cfg_q.fixed_supported);
			REG_FIXED_ENABLE:    prdata = APB_DW'(cfg_q.fixed_enable);
			REG_DEFAULT_TYPE:    prdata = APB_DW'(cfg_q.default_type);
			default:             prdata = '0;
		endcase
	end

endmodule

FILE: rtl/mtr_range_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtr_range_table
// Variable range table and the page classifier shared by every page step.
// ----------------------------------------------------------------------------
module mtr_range_table #(
	parameter int NUM_RANGES = mtr_pkg::NUM_RANGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mtr_pkg::tbl_wr_t           wr,
	input  mtr_pkg::cfg_t              cfg,
	input  logic [mtr_pkg::PFN_W-1:0]  page,
	output logic [mtr_pkg::TYPE_W-1:0] page_type
);
	import mtr_pkg::*;

	logic [PFN_W-1:0]  base_q [NUM_RANGES];
	logic [PFN_W-1:0]  mask_q [NUM_RANGES];
	logic [TYPE_W-1:0] kind_q [NUM_RANGES];
	logic [NUM_RANGES-1:0] on_q;

	for (genvar i = 0; i < NUM_RANGES; i++) begin : g_entry
		logic hit_slot;
		assign hit_slot = wr.en && (32'(wr.slot) == i);

		always_ff @(posedge clk) begin
			if (hit_slot) begin
				base_q[i] <= wr.base & wr.mask;
				mask_q[i] <= wr.mask;
				kind_q[i] <= wr.kind;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				on_q[i] <= 1'b0;
			end else if (hit_slot) begin
				on_q[i] <= wr.valid;
			end
		end
	end

	logic              hit;
	logic [TYPE_W-1:0] best;

	always_comb begin
		hit  = 1'b0;
		best = '1;
		for (int i = 0; i < NUM_RANGES; i++) begin
			if (on_q[i] && ((page & mask_q[i]) == base_q[i])) begin
				if (!hit || kind_q[i] < best) best = kind_q[i];
				hit = 1'b1;
			end
		end
		if (!cfg.typing_en) begin
			page_type = '0;
		end else if ((page[PFN_W-1:FIXED_SHIFT] == '0) && cfg.fixed_supported
				&& cfg.fixed_enable) begin
			page_type = '0;
		end else if (hit) begin
			page_type = best;
		end else begin
			page_type = cfg.default_type;
		end
	end

endmodule

FILE: rtl/mtr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtr_seq
// Query sequencer: walks the pages of a request, one per cycle, and keeps
// the lowest type in the result register.
// ----------------------------------------------------------------------------
module mtr_seq #(
	parameter int MAX_PAGES = mtr_pkg::MAX_PAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic                       op,
	input  logic [mtr_pkg::ADDR_W-1:0] address,
	input  logic [mtr_pkg::SIZE_W-1:0] size_bytes,
	output logic [mtr_pkg::PFN_W-1:0]  page,
	input  logic [mtr_pkg::TYPE_W-1:0] page_type,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [mtr_pkg::TYPE_W-1:0] res_type
);
	import mtr_pkg::*;

	localparam int RW = $clog2(MAX_PAGES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [PFN_W-1:0]  page_q;
	logic [RW-1:0]     rem_q;
	logic [TYPE_W-1:0] res_q;
	logic              first_q;
	logic              out_valid_q;
	logic [TYPE_W-1:0] out_type_q;

	logic [SIZE_W:0]   size_up;
	logic [PCNT_W-1:0] pages;
	logic [RW-1:0]     pages_clip;
	logic [TYPE_W-1:0] res_next;
	logic              out_load;

	assign size_up = {1'b0, size_bytes} + (SIZE_W + 1)'(PAGE_OFFSET);
	assign pages   = size_up[SIZE_W:PAGE_SHIFT];

	always_comb begin
		if (32'(pages) > MAX_PAGES) pages_clip = RW'(MAX_PAGES);
		else pages_clip = RW'(pages);
	end

	assign res_next = (first_q || page_type < res_q) ? page_type : res_q;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign s_tready = (state_q == ST_IDLE);
	assign page     = page_q;
	assign m_tvalid = out_valid_q;
	assign res_type = out_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && op_t'(op) == OP_QUERY) begin
						page_q  <= address[ADDR_W-1:PAGE_SHIFT];
						rem_q   <= pages_clip;
						res_q   <= '0;
						first_q <= 1'b1;
						if (pages_clip == '0) state_q <= ST_DONE;
						else state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					res_q   <= res_next;
					first_q <= 1'b0;
					rem_q   <= rem_q - RW'(1);
					page_q  <= page_q + PFN_W'(1);
					if (res_next == '0 || rem_q == RW'(1) || &page_q) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_type_q <= res_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/mtrr_memory_type_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtrr_memory_type_resolver
// Resolves the memory type of a physical region against a variable range
// table.
//
// Requests arrive on the s_ stream. tuser selects the kind: a write request
// loads one range slot and gives no result; a query request gives one
// memory type on the m_ stream. Global enables and the default type sit in
// four registers on the APB port, to be written only while the block is
// idle: the user is bound by this, the block itself does not enforce it.
// A query is loaded, walked page by page (at most MAX_PAGES pages, fewer
// when a page resolves uncacheable or the walk reaches the top page
// frame), and its result is then moved into the output register. The page
// walk is bounded by the single page classifier, which compares all ranges
// in parallel each cycle. s_tready is low for the whole walk. The output
// register holds a result until the receiver takes it; a new query may be
// walked meanwhile, and waits for the register to drain. Reset clears the
// registers, all range valid bits and both streams.
// ----------------------------------------------------------------------------
module mtrr_memory_type_resolver #(
	parameter int NUM_RANGES = mtr_pkg::NUM_RANGES_DEF,
	parameter int MAX_PAGES  = mtr_pkg::MAX_PAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// slot[2:0] range_base_pfn[42:3] range_mask_pfn[82:43] range_type[90:83]
	// range_valid[91] address[143:92] size_bytes[165:144]
	input  logic [mtr_pkg::S_DATA_W-1:0] s_tdata,
	// op[0]
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// resolved type[7:0]
	output logic [mtr_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mtr_pkg::APB_AW-1:0]   paddr,
	input  logic [mtr_pkg::APB_DW-1:0]   pwdata,
	output logic [mtr_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import mtr_pkg::*;

	cfg_t              cfg;
	tbl_wr_t           tbl_wr;
	logic [PFN_W-1:0]  page;
	logic [TYPE_W-1:0] page_type;
	logic [TYPE_W-1:0] res_type;

	assign tbl_wr.en    = s_tvalid && s_tready && (op_t'(s_tuser) == OP_WRITE);
	assign tbl_wr.slot  = s_tdata[2:0];
	assign tbl_wr.base  = s_tdata[42:3];
	assign tbl_wr.mask  = s_tdata[82:43];
	assign tbl_wr.kind  = s_tdata[90:83];
	assign tbl_wr.valid = s_tdata[91];

	assign m_tdata = res_type;

	mtr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mtr_range_table #(
		.NUM_RANGES (NUM_RANGES)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (tbl_wr),
		.cfg       (cfg),
		.page      (page),
		.page_type (page_type)
	);

	mtr_seq #(
		.MAX_PAGES (MAX_PAGES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.op         (s_tuser),
		.address    (s_tdata[143:92]),
		.size_bytes (s_tdata[165:144]),
		.page       (page),
		.page_type  (page_type),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res_type   (res_type)
	);

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the memory type resolver.
//
// Range writes and region queries go in on the request stream; the global
// registers are programmed over APB while the block is idle. A scoreboard
// class keeps its own copy of the range table and the registers, walks the
// pages of every accepted query and checks each memory type that comes out
// on the result stream. A short directed part is followed by random phases
// with different sender idling and receiver back-pressure, one of which
// holds the result side off long enough for the request side to back up.
// ----------------------------------------------------------------------------
module tb;
	import mtr_pkg::*;

	localparam int               N_RANGES    = NUM_RANGES_DEF;
	localparam int               WALK_LIMIT  = MAX_PAGES_DEF;
	localparam logic [PFN_W-1:0] PFN_TOP     = '1;
	localparam int               STALL_LIMIT = 20000;
	localparam int               HOLD_CYCLES = 3000;
	localparam int               PHASE_ITEMS = 120;

	typedef struct packed {
		logic [S_DATA_W-167:0] pad;
		logic [SIZE_W-1:0]     size_bytes;
		logic [ADDR_W-1:0]     address;
		logic                  range_valid;
		logic [TYPE_W-1:0]     range_type;
		logic [PFN_W-1:0]      range_mask_pfn;
		logic [PFN_W-1:0]      range_base_pfn;
		logic [SLOT_W-1:0]     slot;
	} request_t;

	class mem_type_scoreboard;
		cfg_t              cfg = '0;
		logic [PFN_W-1:0]  base_pfn [N_RANGES];
		logic [PFN_W-1:0]  mask_pfn [N_RANGES];
		logic [TYPE_W-1:0] kind     [N_RANGES];
		bit                live     [N_RANGES];
		logic [TYPE_W-1:0] expected_types [$];
		int                mismatches;
		int                slot_writes;
		int                queries;
		int                results;

		function void set_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
			case (idx)
				REG_TYPING_EN:       cfg.typing_en       = value[0];
				REG_FIXED_SUPPORTED: cfg.fixed_supported = value[0];
				REG_FIXED_ENABLE:    cfg.fixed_enable    = value[0];
				REG_DEFAULT_TYPE:    cfg.default_type    = value[TYPE_W-1:0];
				default:             ;
			endcase
		endfunction

		function logic [TYPE_W-1:0] classify_page(logic [PFN_W-1:0] page);
			logic              hit;
			logic [TYPE_W-1:0] best;
			hit  = 1'b0;
			best = '1;
			if (!cfg.typing_en)
				return '0;
			if (page < FIXED_LIMIT && cfg.fixed_supported && cfg.fixed_enable)
				return '0;
			for (int i = 0; i < N_RANGES; i++)
				if (live[i] && (page & mask_pfn[i]) == (base_pfn[i] & mask_pfn[i])) begin
					if (!hit || kind[i] < best)
						best = kind[i];
					hit = 1'b1;
				end
			return hit ? best : cfg.default_type;
		endfunction

		function logic [TYPE_W-1:0] resolve_region(logic [ADDR_W-1:0] addr,
				logic [SIZE_W-1:0] size);
			logic [63:0]       pages;
			logic [63:0]       pg;
			logic [TYPE_W-1:0] t;
			logic [TYPE_W-1:0] lowest;
			logic              any;
			pages  = (64'(size) + PAGE_OFFSET) >> PAGE_SHIFT;
			lowest = '0;
			any    = 1'b0;
			if (pages > WALK_LIMIT)
				pages = WALK_LIMIT;
			for (int k = 0; k < pages; k++) begin
				pg = 64'(addr[ADDR_W-1:PAGE_SHIFT]) + 64'(k);
				if (pg > 64'(PFN_TOP))
					break;
				t = classify_page(pg[PFN_W-1:0]);
				if (!any || t < lowest)
					lowest = t;
				any = 1'b1;
				if (lowest == 0)
					break;
			end
			return lowest;
		endfunction

		function void note_request(op_t op, request_t r);
			if (op == OP_WRITE) begin
				slot_writes++;
				if (r.slot < N_RANGES) begin
					base_pfn[r.slot] = r.range_base_pfn;
					mask_pfn[r.slot] = r.range_mask_pfn;
					kind[r.slot]     = r.range_type;
					live[r.slot]     = r.range_valid;
				end
			end else begin
				queries++;
				expected_types.push_back(resolve_region(r.address, r.size_bytes));
			end
		endfunction

		function void check_result(logic [TYPE_W-1:0] got);
			logic [TYPE_W-1:0] want;
			results++;
			if (expected_types.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: unexpected type 0x%02h", results, got);
				return;
			end
			want = expected_types.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected type 0x%02h, got 0x%02h",
						results, want, got);
			end
		endfunction
	endclass

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic                s_tuser  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [APB_AW-1:0]   paddr    = '0;
	logic [APB_DW-1:0]   pwdata   = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	mem_type_scoreboard mem_types;
	logic [PFN_W-1:0]   recent_base [N_RANGES] = '{default: '0};
	int                 tx_idle_pct   = 0;
	int                 rx_stall_pct  = 0;
	bit                 hold_request  = 1'b0;
	int                 quiet_cycles  = 0;

	mtrr_memory_type_resolver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				mem_types.check_result(m_tdata);
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	function automatic request_t noise();
		logic [191:0] wide;
		request_t     r;
		wide  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r     = wide[S_DATA_W-1:0];
		r.pad = '0;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] page_addr(logic [PFN_W-1:0] pfn,
			logic [PAGE_SHIFT-1:0] offset);
		return {pfn, offset};
	endfunction

	function automatic logic [PFN_W-1:0] pick_pfn();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0:       return PFN_W'($urandom_range(0, 'h2FF));
			1:       return PFN_W'($urandom_range(0, 'hFFFF));
			2:       return PFN_TOP - PFN_W'($urandom_range(0, 'h3FF));
			3:       return r[PFN_W-1:0];
			default: return recent_base[$urandom_range(0, N_RANGES - 1)];
		endcase
	endfunction

	function automatic logic [PFN_W-1:0] pick_mask();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return PFN_TOP;
			2:       return r[PFN_W-1:0];
			default: return PFN_TOP << $urandom_range(0, 12);
		endcase
	endfunction

	function automatic logic [TYPE_W-1:0] pick_type();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return TYPE_W'($urandom_range(0, 255));
			default: return TYPE_W'($urandom_range(1, 7));
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_address();
		logic [PFN_W-1:0] pfn;
		pfn = pick_pfn();
		if ($urandom_range(0, 1))
			pfn = pfn - PFN_W'($urandom_range(0, 4));
		return page_addr(pfn, PAGE_SHIFT'($urandom));
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int n;
		n = $urandom_range(0, 99);
		if (n < 70)
			return SIZE_W'($urandom_range(0, 16 * PAGE_BYTES));
		if (n < 90)
			return SIZE_W'($urandom_range(0, 64 * PAGE_BYTES));
		if (n < 98)
			return SIZE_W'($urandom_range(0, WALK_LIMIT * PAGE_BYTES));
		return SIZE_W'(WALK_LIMIT * PAGE_BYTES);
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		mem_types.set_reg(idx, value);
	endtask

	task automatic set_config(bit en, bit fsup, bit fen, logic [TYPE_W-1:0] dflt);
		apb_write(REG_TYPING_EN, APB_DW'(en));
		apb_write(REG_FIXED_SUPPORTED, APB_DW'(fsup));
		apb_write(REG_FIXED_ENABLE, APB_DW'(fen));
		apb_write(REG_DEFAULT_TYPE, APB_DW'(dflt));
	endtask

	task automatic send(op_t op, request_t r);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= r;
		do @(posedge clk); while (!s_tready);
		mem_types.note_request(op, r);
	endtask

	task automatic send_range(logic [SLOT_W-1:0] slot, logic [PFN_W-1:0] base,
			logic [PFN_W-1:0] mask, logic [TYPE_W-1:0] kind, logic valid);
		request_t r;
		r                = noise();
		r.slot           = slot;
		r.range_base_pfn = base;
		r.range_mask_pfn = mask;
		r.range_type     = kind;
		r.range_valid    = valid;
		recent_base[slot] = base;
		send(OP_WRITE, r);
	endtask

	task automatic send_query(logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
		request_t r;
		r            = noise();
		r.address    = addr;
		r.size_bytes = size;
		send(OP_QUERY, r);
	endtask

	task automatic random_request();
		if ($urandom_range(0, 99) < 30)
			send_range(SLOT_W'($urandom_range(0, 7)), pick_pfn(), pick_mask(), pick_type(),
				$urandom_range(0, 9) != 0);
		else
			send_query(pick_address(), pick_size());
	endtask

	// drop the request stream and let the block deliver every outstanding query result
	task automatic drain();
		s_tvalid <= 1'b0;
		while (mem_types.expected_types.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		mem_types = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_query('0, SIZE_W'(PAGE_BYTES));
		send_query('1, SIZE_W'(WALK_LIMIT * PAGE_BYTES));
		drain();
		set_config(1'b1, 1'b1, 1'b1, 8'h55);
		send_range(SLOT_W'(0), PFN_W'('h100), PFN_TOP << 4, 8'd6, 1'b1);
		send_range(SLOT_W'(1), PFN_W'('h108), PFN_TOP << 3, 8'd4, 1'b1);
		send_range(SLOT_W'(2), PFN_TOP, PFN_TOP, 8'hFF, 1'b1);
		send_range(SLOT_W'(3), PFN_W'('h200), PFN_TOP, 8'd0, 1'b1);
		send_range(SLOT_W'(7), PFN_TOP, '0, 8'hFF, 1'b0);
		send_query(page_addr(PFN_W'('h100), '1), SIZE_W'(1));
		send_query(page_addr(PFN_W'('h100), '0), SIZE_W'(16 * PAGE_BYTES));
		send_query(page_addr(PFN_W'('h110), '0), '0);
		send_query(page_addr(PFN_W'('h110), '0), SIZE_W'(PAGE_BYTES));
		send_query(page_addr(PFN_W'('hFF), '0), SIZE_W'(2 * PAGE_BYTES));
		send_query(page_addr(PFN_W'('h1FF), '0), SIZE_W'(3 * PAGE_BYTES));
		send_query('1, SIZE_W'(WALK_LIMIT * PAGE_BYTES));
		send_query(page_addr(PFN_TOP - 1, '0), SIZE_W'(WALK_LIMIT * PAGE_BYTES - 1));
		send_query(page_addr(PFN_W'('h12345678), '0), SIZE_W'(WALK_LIMIT * PAGE_BYTES));
		send_range(SLOT_W'(7), PFN_TOP, '0, 8'hFF, 1'b1);
		send_query(page_addr(PFN_W'('h110), '0), SIZE_W'(PAGE_BYTES));
		send_range(SLOT_W'(6), PFN_W'('h300), PFN_TOP << 8, 8'd0, 1'b0);
		send_query(page_addr(PFN_W'('h300), '0), SIZE_W'(4 * PAGE_BYTES));

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					set_config(1'b1, 1'b1, 1'b1, TYPE_W'($urandom_range(0, 255)));
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
					// hold the result stream so that the request side backs up
					hold_request = 1'b1;
				end
				1: begin
					set_config(1'b1, 1'b1, 1'b0, 8'hFF);
					tx_idle_pct  = 76;
					rx_stall_pct = 0;
				end
				2: begin
					set_config(1'b1, 1'b0, 1'b1, 8'h00);
					tx_idle_pct  = 0;
					rx_stall_pct = 76;
				end
				default: begin
					set_config(1'b1, 1'b0, 1'b0, TYPE_W'($urandom_range(0, 255)));
					tx_idle_pct  = 20;
					rx_stall_pct = 20;
				end
			endcase
			repeat (PHASE_ITEMS) random_request();
		end

		drain();
		repeat (WALK_LIMIT + 8) @(posedge clk);
		mem_types.mismatches += mem_types.expected_types.size();
		$display("Covered %0d range writes and %0d queries across four idling phases",
			mem_types.slot_writes, mem_types.queries);
		$display("with one long result hold; %0d memory types checked, %0d mismatches.",
			mem_types.results, mem_types.mismatches);
		if (mem_types.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mtr_pkg.sv
rtl/mtr_cfg.sv
rtl/mtr_range_table.sv
rtl/mtr_seq.sv
rtl/mtrr_memory_type_resolver.sv
verif/tb.sv
